>>> rtl/cusbrx_pkg.sv
package cusbrx_pkg;

    localparam int unsigned REC_LAST = 17;
    localparam int unsigned POS_W = 5;

    localparam logic [7:0] ST_BOFF = 8'h80;
    localparam logic [7:0] ST_EWRN = 8'h40;
    localparam logic [7:0] ST_BERR = 8'h20;

    localparam logic [7:0] CODE_CLEAR_ALL  = 8'h00;
    localparam logic [7:0] CODE_CLEAR_WARN = 8'h02;
    localparam logic [7:0] CODE_SET_WARN   = 8'h03;
    localparam logic [7:0] CODE_BUS_OFF    = 8'h04;
    localparam logic [7:0] CODE_BERR_A     = 8'h20;
    localparam logic [7:0] CODE_BERR_B     = 8'h21;
    localparam logic [7:0] CODE_BERR_C     = 8'h23;
    localparam logic [7:0] CODE_BERR_D     = 8'h24;
    localparam logic [7:0] CODE_BERR_E     = 8'h25;
    localparam logic [7:0] CODE_BERR_F     = 8'h27;

    localparam logic [7:0] STATUS_DLC = 8'h04;

    typedef enum logic [1:0] {
        REG_DROP_EXTENDED = 2'd0,
        REG_DROP_REMOTE   = 2'd1,
        REG_DROP_STATUS   = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [7:0]  rx_byte;
        logic        buffer_start;
        logic [63:0] now_usec;
    } in_item_t;

    typedef struct packed {
        logic        is_extended;
        logic        is_remote;
        logic        is_status;
        logic [31:0] identifier;
        logic [7:0]  length_code;
        logic [63:0] payload;
        logic [63:0] stamp_usec;
    } out_item_t;

    typedef struct packed {
        logic drop_extended;
        logic drop_remote;
        logic drop_status;
    } drop_cfg_t;

    function automatic logic [7:0] status_update(input logic [7:0] flags,
                                                 input logic [7:0] code);
        logic [7:0] f;
        f = flags;
        case (code)
            CODE_CLEAR_ALL:  f = flags & ~(ST_BOFF | ST_EWRN | ST_BERR);
            CODE_CLEAR_WARN: f = flags & ~ST_EWRN;
            CODE_SET_WARN:   f = flags | ST_EWRN;
            CODE_BUS_OFF:    f = flags | ST_BOFF;
            CODE_BERR_A, CODE_BERR_B, CODE_BERR_C,
            CODE_BERR_D, CODE_BERR_E, CODE_BERR_F:
                             f = flags | ST_BERR;
            default:         f = flags;
        endcase
        return f;
    endfunction

endpackage

>>> rtl/cusbrx_decode.sv
module cusbrx_decode (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  cusbrx_pkg::in_item_t  item,
    input  cusbrx_pkg::drop_cfg_t cfg,
    output logic                  res_valid,
    output cusbrx_pkg::out_item_t res
);
    import cusbrx_pkg::*;

    localparam logic [POS_W-1:0] POS_LAST = POS_W'(REC_LAST);

    logic [POS_W-1:0] pos_reg, pos_next, pos;
    logic [2:0]       flags_reg, flags_next;
    logic [31:0]      id_reg, id_next;
    logic [7:0]       dlc_reg, dlc_next;
    logic [63:0]      payload_reg, payload_next;
    logic [31:0]      stamp_reg, stamp_next;
    logic [7:0]       st_flags_reg, st_flags_next;
    logic [7:0]       bus_state_reg, bus_state_next;
    logic [7:0]       rec_reg, rec_next;
    logic [7:0]       tec_reg, tec_next;
    logic [63:0]      origin_reg, origin_next;

    logic        last;
    logic [31:0] hw;
    logic [63:0] hw_ext, diff, stamp, payload;
    logic        origin_zero, mapped, ext, rtr, sts, suppress;
    logic [7:0]  code, dlc;

    always_comb
    begin
        pos = (item.buffer_start || pos_reg > POS_LAST) ? '0 : pos_reg;
        last = (pos == POS_LAST);
        hw = {stamp_reg[23:0], item.rx_byte};
        hw_ext = {32'd0, hw};
        origin_zero = (origin_reg == 64'd0);
        diff = item.now_usec - origin_reg;
        stamp = origin_zero ? hw_ext : hw_ext + {diff[63:32], 32'd0};

        code = payload_reg[63:56];
        mapped = flags_reg[2] && (dlc_reg != 8'd0);

        pos_next = pos_reg;
        flags_next = flags_reg;
        id_next = id_reg;
        dlc_next = dlc_reg;
        payload_next = payload_reg;
        stamp_next = stamp_reg;
        st_flags_next = st_flags_reg;
        bus_state_next = bus_state_reg;
        rec_next = rec_reg;
        tec_next = tec_reg;
        origin_next = origin_reg;

        if (en)
        begin
            if (pos == '0)
                flags_next = item.rx_byte[2:0];
            else if (pos <= POS_W'(4))
                id_next = {id_reg[23:0], item.rx_byte};
            else if (pos == POS_W'(5))
                dlc_next = item.rx_byte;
            else if (pos <= POS_W'(13))
                payload_next = {payload_reg[55:0], item.rx_byte};
            else if (!last)
                stamp_next = {stamp_reg[23:0], item.rx_byte};

            if (last)
            begin
                pos_next = '0;
                if (origin_zero)
                    origin_next = item.now_usec - hw_ext;
                if (mapped)
                begin
                    st_flags_next = status_update(st_flags_reg, code);
                    bus_state_next = code;
                    if (dlc_reg >= 8'd2)
                        rec_next = payload_reg[55:48];
                    if (dlc_reg >= 8'd3)
                        tec_next = payload_reg[47:40];
                end
            end
            else
            begin
                pos_next = pos + POS_W'(1);
            end
        end

        ext = mapped ? 1'b0 : flags_reg[0];
        rtr = mapped ? 1'b0 : flags_reg[1];
        sts = flags_reg[2];
        dlc = mapped ? STATUS_DLC : dlc_reg;
        payload = mapped ? {st_flags_next, bus_state_next, rec_next, tec_next,
                            payload_reg[31:0]}
                         : payload_reg;

        suppress = (ext && cfg.drop_extended) || (rtr && cfg.drop_remote) ||
                   (sts && cfg.drop_status) || (sts && stamp == 64'd0);

        res_valid = en && last && !suppress;
        res.is_extended = ext;
        res.is_remote = rtr;
        res.is_status = sts;
        res.identifier = mapped ? 32'd0 : id_reg;
        res.length_code = dlc;
        res.payload = payload;
        res.stamp_usec = stamp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            flags_reg <= '0;
            id_reg <= '0;
            dlc_reg <= '0;
            payload_reg <= '0;
            stamp_reg <= '0;
            st_flags_reg <= '0;
            bus_state_reg <= '0;
            rec_reg <= '0;
            tec_reg <= '0;
            origin_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            flags_reg <= flags_next;
            id_reg <= id_next;
            dlc_reg <= dlc_next;
            payload_reg <= payload_next;
            stamp_reg <= stamp_next;
            st_flags_reg <= st_flags_next;
            bus_state_reg <= bus_state_next;
            rec_reg <= rec_next;
            tec_reg <= tec_next;
            origin_reg <= origin_next;
        end
    end

endmodule

>>> rtl/can_usb_rx_record_decoder_top.sv
// channel   | direction | handshake            | content
// byte_*    | in        | valid / stall        | one stream byte, buffer mark, time
// rec_*     | out       | valid / stall        | one decoded record
// cfg_*     | in        | valid / ready        | drop mode register write
//
// One byte per cycle unless stalled; a record leaves through the result register.
// Path: input register, decode in one pass, result register.
// Reset clears record position, status tracking and time origin.
// A stalled output holds both registers; stall to the input follows.
module can_usb_rx_record_decoder_top (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  byte_valid,
    output logic                  byte_stall,
    input  cusbrx_pkg::in_item_t  byte_item,
    output logic                  rec_valid,
    input  logic                  rec_stall,
    output cusbrx_pkg::out_item_t rec_item,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic                  cfg_data
);
    import cusbrx_pkg::*;

    logic      advance;
    logic      in_valid_reg;
    in_item_t  in_item_reg;
    drop_cfg_t cfg_reg;
    logic      res_valid;
    out_item_t res;
    logic      out_valid_reg;
    out_item_t out_item_reg;

    assign advance = !out_valid_reg || !rec_stall;
    assign byte_stall = !advance;
    assign cfg_ready = 1'b1;
    assign rec_valid = out_valid_reg;
    assign rec_item = out_item_reg;

    cusbrx_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (in_valid_reg && advance),
        .item      (in_item_reg),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            cfg_reg <= '{drop_extended: 1'b0, drop_remote: 1'b0, drop_status: 1'b1};
        end
        else
        begin
            if (advance)
            begin
                in_valid_reg <= byte_valid;
                out_valid_reg <= res_valid;
            end
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_DROP_EXTENDED: cfg_reg.drop_extended <= cfg_data;
                    REG_DROP_REMOTE:   cfg_reg.drop_remote <= cfg_data;
                    REG_DROP_STATUS:   cfg_reg.drop_status <= cfg_data;
                    default:           cfg_reg <= cfg_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            in_item_reg <= byte_item;
            out_item_reg <= res;
        end
    end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import cusbrx_pkg::*;

    localparam int DRAIN_CYCLES = 8;
    localparam int QUIET_LIMIT = 5000;
    localparam int PHASE_RECORDS = 13;
    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam logic [7:0] CODE_NO_CHANGE = 8'h01;
    localparam logic [7:0] CODE_OTHER = 8'h55;

    class decoded_record_board;
        logic        drop_ext;
        logic        drop_rem;
        logic        drop_sts;
        logic [4:0]  pos;
        logic [2:0]  flags_q;
        logic [31:0] id_q;
        logic [7:0]  dlc_q;
        logic [63:0] data_q;
        logic [31:0] hw_q;
        logic [7:0]  bus_flags;
        logic [7:0]  bus_code;
        logic [7:0]  rx_errs;
        logic [7:0]  tx_errs;
        logic [63:0] time_base;
        out_item_t   due_records[$];
        int          errors;

        function new();
            drop_ext = 1'b0;
            drop_rem = 1'b0;
            drop_sts = 1'b1;
            pos = '0;
            flags_q = '0;
            id_q = '0;
            dlc_q = '0;
            data_q = '0;
            hw_q = '0;
            bus_flags = '0;
            bus_code = '0;
            rx_errs = '0;
            tx_errs = '0;
            time_base = '0;
            errors = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic v);
            case (idx)
                REG_DROP_EXTENDED: drop_ext = v;
                REG_DROP_REMOTE:   drop_rem = v;
                REG_DROP_STATUS:   drop_sts = v;
                default: ;
            endcase
        endfunction

        function logic [7:0] next_bus_flags(logic [7:0] cur, logic [7:0] code);
            case (code)
                CODE_CLEAR_ALL:  return cur & ~(ST_BOFF | ST_EWRN | ST_BERR);
                CODE_CLEAR_WARN: return cur & ~ST_EWRN;
                CODE_SET_WARN:   return cur | ST_EWRN;
                CODE_BUS_OFF:    return cur | ST_BOFF;
                CODE_BERR_A, CODE_BERR_B, CODE_BERR_C,
                CODE_BERR_D, CODE_BERR_E, CODE_BERR_F:
                    return cur | ST_BERR;
                default:         return cur;
            endcase
        endfunction

        function int pending();
            return due_records.size();
        endfunction

        function void take_byte(in_item_t it);
            logic [7:0]  b;
            logic [4:0]  p;
            logic [31:0] hw;
            logic [63:0] stamp;
            logic [63:0] data;
            logic [31:0] ident;
            logic [7:0]  dlc;
            logic        e;
            logic        r;
            logic        s;
            out_item_t   rec;
            b = it.rx_byte;
            if (it.buffer_start || pos > REC_LAST)
                pos = '0;
            p = pos;
            if (p == 0)
                flags_q = b[2:0];
            else if (p <= 4)
                id_q = {id_q[23:0], b};
            else if (p == 5)
                dlc_q = b;
            else if (p <= 13)
                data_q = {data_q[55:0], b};
            else if (p < REC_LAST)
                hw_q = {hw_q[23:0], b};
            if (p < REC_LAST)
            begin
                pos = p + 5'd1;
                return;
            end
            pos = '0;

            hw = {hw_q[23:0], b};
            if (time_base == 64'd0)
                time_base = it.now_usec - {32'd0, hw};
            stamp = {32'd0, hw} + ((it.now_usec - time_base) & 64'hFFFF_FFFF_0000_0000);

            e = flags_q[0];
            r = flags_q[1];
            s = flags_q[2];
            ident = id_q;
            dlc = dlc_q;
            data = data_q;
            if (s && dlc != 8'd0)
            begin
                bus_flags = next_bus_flags(bus_flags, data[63:56]);
                bus_code = data[63:56];
                if (dlc >= 8'd2)
                    rx_errs = data[55:48];
                if (dlc >= 8'd3)
                    tx_errs = data[47:40];
                e = 1'b0;
                r = 1'b0;
                ident = '0;
                dlc = STATUS_DLC;
                data = {bus_flags, bus_code, rx_errs, tx_errs, data[31:0]};
            end

            if ((e && drop_ext) || (r && drop_rem) || (s && drop_sts) ||
                (s && stamp == 64'd0))
                return;

            rec.is_extended = e;
            rec.is_remote = r;
            rec.is_status = s;
            rec.identifier = ident;
            rec.length_code = dlc;
            rec.payload = data;
            rec.stamp_usec = stamp;
            due_records.push_back(rec);
        endfunction

        function void check_record(out_item_t got);
            out_item_t want;
            if (due_records.size() == 0)
            begin
                $error("record received with none expected");
                errors++;
                return;
            end
            want = due_records.pop_front();
            if (got.is_extended !== want.is_extended)
            begin
                $error("is_extended: expected %0b, actual %0b", want.is_extended, got.is_extended);
                errors++;
            end
            if (got.is_remote !== want.is_remote)
            begin
                $error("is_remote: expected %0b, actual %0b", want.is_remote, got.is_remote);
                errors++;
            end
            if (got.is_status !== want.is_status)
            begin
                $error("is_status: expected %0b, actual %0b", want.is_status, got.is_status);
                errors++;
            end
            if (got.identifier !== want.identifier)
            begin
                $error("identifier: expected %h, actual %h", want.identifier, got.identifier);
                errors++;
            end
            if (got.length_code !== want.length_code)
            begin
                $error("length_code: expected %h, actual %h", want.length_code, got.length_code);
                errors++;
            end
            if (got.payload !== want.payload)
            begin
                $error("payload: expected %h, actual %h", want.payload, got.payload);
                errors++;
            end
            if (got.stamp_usec !== want.stamp_usec)
            begin
                $error("stamp_usec: expected %h, actual %h", want.stamp_usec, got.stamp_usec);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n = 1'b0;
    logic        byte_valid = 1'b0;
    logic        byte_stall;
    in_item_t    byte_item = '0;
    logic        rec_valid;
    logic        rec_stall = 1'b0;
    out_item_t   rec_item;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic        cfg_data = 1'b0;

    decoded_record_board board = new();
    int          idle_pct = 22;
    int          quiet_cycles = 0;
    logic [63:0] now_t = '0;
    logic        need_mark = 1'b1;

    can_usb_rx_record_decoder_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .rec_valid  (rec_valid),
        .rec_stall  (rec_stall),
        .rec_item   (rec_item),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && rec_valid && !rec_stall)
            board.check_record(rec_item);
        rec_stall <= ($urandom_range(99) < idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((byte_valid && !byte_stall) || (rec_valid && !rec_stall) ||
                (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [31:0] hw_for(logic [63:0] now);
        logic [63:0] d;
        d = now - board.time_base;
        return d[31:0];
    endfunction

    function automatic logic [7:0] pick_code();
        case ($urandom_range(12))
            0:  return CODE_CLEAR_ALL;
            1:  return CODE_NO_CHANGE;
            2:  return CODE_CLEAR_WARN;
            3:  return CODE_SET_WARN;
            4:  return CODE_BUS_OFF;
            5:  return CODE_BERR_A;
            6:  return CODE_BERR_B;
            7:  return CODE_BERR_C;
            8:  return CODE_BERR_D;
            9:  return CODE_BERR_E;
            10: return CODE_BERR_F;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic mark, input logic [63:0] now);
        in_item_t it;
        it.rx_byte = b;
        it.buffer_start = mark;
        it.now_usec = now;
        while ($urandom_range(99) < idle_pct)
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_item <= it;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        board.take_byte(it);
    endtask

    task automatic send_record(input logic [7:0] flags, input logic [31:0] id,
                               input logic [7:0] dlc, input logic [63:0] data,
                               input logic [31:0] hw, input logic [63:0] now,
                               input logic mark, input int cut);
        logic [143:0] rec;
        rec = {flags, id, dlc, data, hw};
        for (int i = 0; i < cut; i++)
            send_byte(rec[143 - 8 * i -: 8], (i == 0) && mark, (i == 17) ? now : rand64());
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.write_reg(idx, v);
    endtask

    task automatic wait_drained();
        byte_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic program_drops(input logic ext, input logic rem, input logic sts);
        wait_drained();
        write_reg(REG_DROP_EXTENDED, ext);
        write_reg(REG_DROP_REMOTE, rem);
        write_reg(REG_DROP_STATUS, sts);
        if ($urandom_range(1))
            write_reg(REG_UNUSED, $urandom_range(1));
        cfg_valid <= 1'b0;
    endtask

    task automatic random_record();
        logic [7:0]  flags;
        logic [7:0]  dlc;
        logic [63:0] data;
        logic [63:0] now;
        logic [31:0] hw;
        logic        mark;
        int          kind;
        int          cut;
        kind = $urandom_range(99);
        if (kind < 7)
        begin
            repeat ($urandom_range(1, 30))
                send_byte(8'($urandom), $urandom_range(9) == 0, rand64());
            need_mark = 1'b1;
            return;
        end
        flags = 8'($urandom);
        flags[2] = ($urandom_range(99) < 35);
        dlc = ($urandom_range(99) < 80) ? 8'($urandom_range(8)) : 8'($urandom);
        data = rand64();
        if (flags[2])
            data[63:56] = pick_code();
        now_t += 64'($urandom_range(1, 5000));
        if ($urandom_range(19) == 0)
            now_t += {32'($urandom_range(3)), $urandom};
        hw = hw_for(now_t);
        if ($urandom_range(9) == 0)
            hw = $urandom;
        now = ($urandom_range(29) == 0) ? rand64() : now_t;
        mark = need_mark || $urandom_range(1);
        cut = (kind < 15) ? $urandom_range(1, 17) : 18;
        send_record(flags, $urandom, dlc, data, hw, now, mark, cut);
        need_mark = (cut < 18);
    endtask

    initial
    begin
        logic [7:0] codes[12];
        logic [7:0] dlcs[5];
        codes = '{CODE_SET_WARN, CODE_BUS_OFF, CODE_BERR_A, CODE_CLEAR_WARN,
                  CODE_BERR_B, CODE_BERR_C, CODE_BERR_D, CODE_BERR_E,
                  CODE_BERR_F, CODE_NO_CHANGE, CODE_OTHER, CODE_CLEAR_ALL};
        dlcs = '{8'd1, 8'd2, 8'd3, 8'd8, 8'hFF};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset modes: status dropped but still tracked; origin stays unset on a zero result
        send_record(8'h04, 32'h0, 8'd1, {CODE_SET_WARN, 56'h0}, 32'h0, 64'h0, 1'b1, 18);
        send_record(8'h00, 32'hFFFF_FFFF, 8'hFF, '1, 32'hFFFF_FFFF, '1, 1'b1, 18);
        now_t = 64'hFFFF_FFFF_0000_1000;

        program_drops(1'b0, 1'b0, 1'b0);
        @(posedge clk);
        write_reg(REG_UNUSED, 1'b1);
        cfg_valid <= 1'b0;

        for (int i = 0; i < 12; i++)
        begin
            now_t += 64'd16;
            send_record((i % 2) ? 8'h07 : 8'hFC, $urandom, dlcs[i % 5],
                        {codes[i], 8'($urandom), 8'($urandom), 40'($urandom)},
                        hw_for(now_t), now_t, 1'b1, 18);
        end
        now_t += 64'd16;
        send_record(8'h04, 32'h1234_5678, 8'd0, rand64(), hw_for(now_t), now_t, 1'b1, 18);
        // status with a zero stamp is never reported
        send_record(8'h04, 32'h0, 8'd2, {CODE_BUS_OFF, 56'h0}, 32'h0,
                    board.time_base + 64'd5, 1'b1, 18);
        now_t += 64'd16;
        send_record(8'h01, 32'h0, 8'd0, 64'h0, hw_for(now_t), now_t, 1'b1, 18);
        send_record(8'h02, 32'hFFFF_FFFF, 8'd8, '1, hw_for(now_t), now_t, 1'b1, 18);
        send_record(8'h03, 32'h1FFF_FFFF, 8'd0, rand64(), hw_for(now_t), now_t, 1'b1, 18);
        // partial record dropped by a new buffer
        send_record(8'h00, $urandom, 8'd8, rand64(), 32'h0, now_t, 1'b1, 7);
        send_record(8'h00, $urandom, 8'd8, rand64(), hw_for(now_t), now_t, 1'b1, 18);

        program_drops(1'b1, 1'b1, 1'b1);
        send_record(8'h01, $urandom, 8'd8, rand64(), hw_for(now_t), now_t, 1'b1, 18);
        send_record(8'h02, $urandom, 8'd8, rand64(), hw_for(now_t), now_t, 1'b1, 18);
        send_record(8'h04, $urandom, 8'd3, {CODE_BERR_A, 56'h0}, hw_for(now_t), now_t, 1'b1, 18);
        send_record(8'h00, $urandom, 8'd8, rand64(), hw_for(now_t), now_t, 1'b1, 18);

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: program_drops(1'b0, 1'b0, 1'b0);
                1: program_drops(1'b1, 1'b1, 1'b1);
                2: program_drops(1'b1, 1'b0, 1'b0);
                3: program_drops(1'b0, 1'b1, 1'b0);
                4: program_drops(1'b0, 1'b0, 1'b1);
                default: program_drops($urandom_range(1), $urandom_range(1), $urandom_range(1));
            endcase
            idle_pct = (ph == 2) ? 0 : 22;
            need_mark = 1'b1;
            repeat (PHASE_RECORDS) random_record();
        end

        wait_drained();
        if (board.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
